@@ design/vpc_pkg.sv @@
package vpc_pkg;

    // Link header lengths
    localparam int unsigned LINK_LOOPBACK_BYTES = 4;
    localparam int unsigned LINK_ETH_BYTES      = 14;

    // IP layer
    localparam logic [3:0] IP_VER_4         = 4'd4;
    localparam logic [3:0] IP_VER_6         = 4'd6;
    localparam logic [5:0] IPV6_HDR_BYTES   = 6'd40;
    localparam int unsigned IPV4_MIN_HDR    = 20;
    localparam int unsigned IPV4_PROTO_OFS  = 9;
    localparam int unsigned IPV6_NEXT_OFS   = 6;
    localparam logic [7:0] PROTO_UDP        = 8'd17;

    // UDP header and payload offsets, counted from the UDP header start
    localparam int unsigned UDP_HDR_BYTES   = 8;
    localparam int unsigned UDP_SRC_HI      = 0;
    localparam int unsigned UDP_SRC_LO      = 1;
    localparam int unsigned UDP_DST_HI      = 2;
    localparam int unsigned UDP_DST_LO      = 3;
    localparam int unsigned UDP_LEN_HI      = 4;
    localparam int unsigned UDP_LEN_LO      = 5;
    localparam int unsigned MARKER_BYTES    = 4;
    localparam int unsigned IKE_VER_OFS     = UDP_HDR_BYTES + 17;
    localparam int unsigned IKE_EXCH_OFS    = UDP_HDR_BYTES + 18;
    localparam int unsigned IKE_MSGID_FIRST = UDP_HDR_BYTES + 20;
    localparam int unsigned IKE_MSGID_LAST  = UDP_HDR_BYTES + 23;
    localparam int unsigned IKE_HDR_BYTES   = 24;
    localparam int unsigned IKE_MIN_ULEN    = 36;
    localparam int unsigned NATT_MIN_ULEN   = 12;
    localparam logic [3:0]  IKE_MAJOR_V2    = 4'd2;

    // IKEv2 exchange types and their reported codes
    localparam logic [7:0] EXCH_SA_INIT     = 8'd34;
    localparam logic [7:0] EXCH_AUTH        = 8'd35;
    localparam logic [7:0] EXCH_CHILD       = 8'd36;
    localparam logic [7:0] EXCH_INFO        = 8'd37;

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_SA_INIT = 3'd1,
        KIND_AUTH    = 3'd2,
        KIND_CHILD   = 3'd3,
        KIND_INFO    = 3'd4
    } exch_kind_t;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_LINK_KIND    = 2'd0;
    localparam logic [1:0] CFG_IKE_PORT     = 2'd1;
    localparam logic [1:0] CFG_NATT_PORT    = 2'd2;
    localparam logic [1:0] CFG_WG_PORT      = 2'd3;
    localparam logic        LINK_KIND_RST   = 1'b1;
    localparam logic [15:0] IKE_PORT_RST    = 16'd500;
    localparam logic [15:0] NATT_PORT_RST   = 16'd4500;
    localparam logic [15:0] WG_PORT_RST     = 16'd51820;

    localparam int unsigned OUT_BYTES       = 12;

    // Per-frame header fields picked out of the byte stream
    typedef struct packed {
        logic [3:0]  ver;
        logic [5:0]  ihb;
        logic [7:0]  proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] udp_len;
        logic [3:0]  ike_major;
        logic [7:0]  exch;
        logic [31:0] msg_id;
        logic        marker_zero;
    } frame_t;

    localparam frame_t FRAME_CLEAR = '{
        ver: 4'd0, ihb: 6'd0, proto: 8'd0, src_port: 16'd0, dst_port: 16'd0,
        udp_len: 16'd0, ike_major: 4'd0, exch: 8'd0, msg_id: 32'd0,
        marker_zero: 1'b1
    };

endpackage

@@ design/vpc_capture.sv @@
// Per-frame field capture by byte offset.
module vpc_capture
    import vpc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 65536,
    parameter int unsigned OFS_W           = $clog2(MAX_FRAME_BYTES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    input  logic [7:0]       byte_data,
    input  logic             byte_last,
    input  logic             link_kind,
    output frame_t           frame_cap,   // fields including the current byte
    output logic [OFS_W-1:0] caplen       // bytes captured including this one
);

    localparam int unsigned CMP_W = (OFS_W > 8) ? OFS_W : 8;

    frame_t           frame_reg, frame_next;
    logic [OFS_W-1:0] offset_reg, offset_next;

    logic [CMP_W-1:0] hdr_len, pos, udp_base, rel;

    always_comb
    begin
        hdr_len  = link_kind ? CMP_W'(LINK_ETH_BYTES) : CMP_W'(LINK_LOOPBACK_BYTES);
        pos      = CMP_W'(offset_reg);
        udp_base = hdr_len + CMP_W'(frame_reg.ihb);
        rel      = pos - udp_base;
        frame_cap = frame_reg;
        caplen    = offset_reg;

        if (offset_reg < OFS_W'(MAX_FRAME_BYTES))
        begin
            caplen = offset_reg + OFS_W'(1);
            if (pos == hdr_len)
            begin
                frame_cap.ver = byte_data[7:4];
                if (byte_data[7:4] == IP_VER_4)
                    frame_cap.ihb = {byte_data[3:0], 2'b00};
                else if (byte_data[7:4] == IP_VER_6)
                    frame_cap.ihb = IPV6_HDR_BYTES;
                else
                    frame_cap.ihb = 6'd0;
            end
            else if (pos > hdr_len)
            begin
                if ((frame_reg.ver == IP_VER_4 && pos == hdr_len + CMP_W'(IPV4_PROTO_OFS)) ||
                    (frame_reg.ver == IP_VER_6 && pos == hdr_len + CMP_W'(IPV6_NEXT_OFS)))
                    frame_cap.proto = byte_data;

                if (frame_reg.ihb != 6'd0 && pos >= udp_base)
                begin
                    if (rel == CMP_W'(UDP_SRC_HI)) frame_cap.src_port[15:8] = byte_data;
                    if (rel == CMP_W'(UDP_SRC_LO)) frame_cap.src_port[7:0]  = byte_data;
                    if (rel == CMP_W'(UDP_DST_HI)) frame_cap.dst_port[15:8] = byte_data;
                    if (rel == CMP_W'(UDP_DST_LO)) frame_cap.dst_port[7:0]  = byte_data;
                    if (rel == CMP_W'(UDP_LEN_HI)) frame_cap.udp_len[15:8]  = byte_data;
                    if (rel == CMP_W'(UDP_LEN_LO)) frame_cap.udp_len[7:0]   = byte_data;
                    if (rel >= CMP_W'(UDP_HDR_BYTES) &&
                        rel <  CMP_W'(UDP_HDR_BYTES + MARKER_BYTES) &&
                        byte_data != 8'd0)
                        frame_cap.marker_zero = 1'b0;
                    if (rel == CMP_W'(IKE_VER_OFS))  frame_cap.ike_major = byte_data[7:4];
                    if (rel == CMP_W'(IKE_EXCH_OFS)) frame_cap.exch = byte_data;
                    if (rel >= CMP_W'(IKE_MSGID_FIRST) && rel <= CMP_W'(IKE_MSGID_LAST))
                        frame_cap.msg_id = {frame_reg.msg_id[23:0], byte_data};
                end
            end
        end

        frame_next  = frame_reg;
        offset_next = offset_reg;
        if (byte_valid)
        begin
            frame_next  = byte_last ? FRAME_CLEAR : frame_cap;
            offset_next = byte_last ? '0 : caplen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg  <= FRAME_CLEAR;
            offset_reg <= '0;
        end
        else
        begin
            frame_reg  <= frame_next;
            offset_reg <= offset_next;
        end
    end

    // frame state is back to clear after the last byte
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_last |=> offset_reg == '0 && frame_reg == FRAME_CLEAR)
        else $error("frame state not cleared after last byte");

    // offset never passes the capture limit
    a_offset_sat: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFS_W'(MAX_FRAME_BYTES))
        else $error("byte offset beyond limit");

endmodule

@@ design/vpn_packet_classifier.sv @@
// Channel | Dir | Handshake         | Payload
// s_*     | in  | s_tvalid/s_tready | s_tdata[7:0] data_byte, s_tlast last_byte
// m_*     | out | m_tvalid/m_tready | m_tdata[95:0] verdict (layout at port)
// cfg_*   | in  | cfg_we            | cfg_index register, cfg_data value
//
// One byte per cycle while no last byte is held back. A byte is registered on
// transfer, then as it advances the per-frame capture and, on the last byte,
// the verdict logic load the output register.
// rst_n (async, active low) clears the frame state and loads port defaults.
// Only a last byte waits for a full output register; other bytes flow on
// while a verdict sits unclaimed on m_*.
module vpn_packet_classifier
    import vpc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] vpn_match, [1] is_ipv6, [17:2] source_port, [33:18] dest_port,
    // [50:34] payload_length, [51] wireguard_seen, [52] ike_seen,
    // [55:53] exchange_kind, [87:56] message_id, [88] natt_esp, rest zero
    output logic [95:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned OFS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CMP_W = (OFS_W > 8) ? OFS_W : 8;

    // configuration
    logic        link_kind_reg;
    logic [15:0] ike_port_reg, natt_port_reg, wg_port_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_kind_reg <= LINK_KIND_RST;
            ike_port_reg  <= IKE_PORT_RST;
            natt_port_reg <= NATT_PORT_RST;
            wg_port_reg   <= WG_PORT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINK_KIND: link_kind_reg <= cfg_data[0];
                CFG_IKE_PORT:  ike_port_reg  <= cfg_data;
                CFG_NATT_PORT: natt_port_reg <= cfg_data;
                CFG_WG_PORT:   wg_port_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       advance;

    // a non-last byte never needs the output register
    assign advance  = in_valid_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // field capture
    frame_t           fr;
    logic [OFS_W-1:0] caplen;

    vpc_capture #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .OFS_W           (OFS_W)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (advance),
        .byte_data  (in_data_reg),
        .byte_last  (in_last_reg),
        .link_kind  (link_kind_reg),
        .frame_cap  (fr),
        .caplen     (caplen)
    );

    // verdict
    logic [CMP_W-1:0] hdr_len, cap_c, ihb_c, pay_start;
    logic             udp_ok, hit, wg, ike, esp;
    logic             src_natt, dst_natt;
    exch_kind_t       kind;
    logic [95:0]      verdict;

    always_comb
    begin
        hdr_len   = link_kind_reg ? CMP_W'(LINK_ETH_BYTES) : CMP_W'(LINK_LOOPBACK_BYTES);
        cap_c     = CMP_W'(caplen);
        ihb_c     = CMP_W'(fr.ihb);
        pay_start = hdr_len + ihb_c + CMP_W'(UDP_HDR_BYTES);

        udp_ok = 1'b0;
        if (cap_c >= hdr_len + CMP_W'(UDP_HDR_BYTES) && fr.proto == PROTO_UDP)
        begin
            if (fr.ver == IP_VER_4)
                udp_ok = cap_c >= hdr_len + CMP_W'(IPV4_MIN_HDR) &&
                         ihb_c >= CMP_W'(IPV4_MIN_HDR) && cap_c >= pay_start;
            else if (fr.ver == IP_VER_6)
                udp_ok = cap_c >= pay_start;
        end

        src_natt = fr.src_port == natt_port_reg;
        dst_natt = fr.dst_port == natt_port_reg;
        wg  = fr.src_port == wg_port_reg || fr.dst_port == wg_port_reg;
        hit = udp_ok && (wg || src_natt || dst_natt ||
                         fr.src_port == ike_port_reg || fr.dst_port == ike_port_reg);

        ike = !wg && fr.udp_len >= 16'(IKE_MIN_ULEN) &&
              cap_c >= pay_start + CMP_W'(IKE_HDR_BYTES) && fr.ike_major == IKE_MAJOR_V2;
        esp = (src_natt || dst_natt) && !wg && fr.udp_len >= 16'(NATT_MIN_ULEN) &&
              cap_c >= pay_start + CMP_W'(MARKER_BYTES) && fr.marker_zero;

        case (fr.exch)
            EXCH_SA_INIT: kind = KIND_SA_INIT;
            EXCH_AUTH:    kind = KIND_AUTH;
            EXCH_CHILD:   kind = KIND_CHILD;
            EXCH_INFO:    kind = KIND_INFO;
            default:      kind = KIND_UNKNOWN;
        endcase

        verdict = '0;
        if (hit)
        begin
            verdict[0]     = 1'b1;
            verdict[1]     = fr.ver == IP_VER_6;
            verdict[17:2]  = fr.src_port;
            verdict[33:18] = fr.dst_port;
            verdict[50:34] = {1'b0, fr.udp_len} - 17'(UDP_HDR_BYTES);
            verdict[51]    = wg;
            verdict[52]    = ike;
            if (ike)
            begin
                verdict[55:53] = kind;
                verdict[87:56] = fr.msg_id;
            end
            verdict[88]    = esp;
        end
    end

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [95:0] out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_data_reg <= verdict;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // no-match verdicts carry nothing else
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata == '0)
        else $error("no-match verdict with nonzero fields");

    // IKE decode only on non-WireGuard traffic
    a_ike_not_wg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[52] |-> !m_tdata[51])
        else $error("ike_seen with wireguard_seen");

    // exchange and message id only with an IKE header
    a_ike_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[52] |-> m_tdata[87:53] == '0)
        else $error("IKE fields without IKE header");

    // input only stalls behind a last byte facing a held verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && in_last_reg && m_tvalid && !m_tready)
        else $error("input stalled without cause");

endmodule
